FILE: design/focic_pkg.sv
// ----------------------------------------------------------------------------
// focic_pkg
// Shared types, constants, microprogram and helper functions for the
// impedance-controlled field-oriented current loop.
// ----------------------------------------------------------------------------
package focic_pkg;

    typedef struct packed {
        logic [11:0] encoder_angle;
        logic [11:0] current_a_sample;
        logic [11:0] current_b_sample;
    } t_in;

    typedef struct packed {
        logic [11:0] duty_u;
        logic [11:0] duty_v;
        logic [11:0] duty_w;
    } t_out;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURRENT_KP        = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURRENT_KI_TS     = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPRING_GAIN       = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DAMPER_GAIN       = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_ANGLE      = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELECTRICAL_OFFSET = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_CURRENT_A    = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_CURRENT_B    = 4'd7;

    localparam logic [31:0] RST_CURRENT_KP    = 32'd13848000;
    localparam logic [31:0] RST_CURRENT_KI_TS = 32'd25960;
    localparam logic [31:0] RST_SPRING_GAIN   = 32'd2340;
    localparam logic [31:0] RST_DAMPER_GAIN   = 32'd780000;
    localparam logic [11:0] RST_ZERO_CURRENT  = 12'd1850;

    localparam logic [15:0] QUARTER_TURN   = 16'd16384;
    localparam logic [32:0] INV_SQRT3_Q15  = 33'd18919;
    localparam logic [32:0] HALF_SQRT3_Q15 = 33'd28378;
    localparam logic [32:0] HALF_Q15       = 33'd16384;
    localparam logic [32:0] SINE_SCALE     = 33'd32767;

    // odd polynomial coefficients, q30
    localparam logic [30:0] C1  = 31'd1686629713;
    localparam logic [30:0] C3  = 31'd693598668;
    localparam logic [30:0] C5  = 31'd85569306;
    localparam logic [30:0] C7  = 31'd5026995;
    localparam logic [30:0] C9  = 31'd172272;
    localparam logic [30:0] C11 = 31'd3864;
    localparam logic [30:0] C13 = 31'd61;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD,
        OP_TORQ_M1, OP_TORQ_M2, OP_TORQ_END, OP_BETA_END,
        OP_SIN_START, OP_SIN_U2, OP_SIN_HMUL, OP_SIN_HSUB,
        OP_SIN_MUL_U, OP_SIN_MUL_Y, OP_SIN_END,
        OP_PARK1, OP_PARK2, OP_PARK3, OP_PARK4, OP_PARK5,
        OP_INTEG,
        OP_VOLT1, OP_VOLT2, OP_VOLT3, OP_VOLT4, OP_VOLT5,
        OP_IPARK1, OP_IPARK2, OP_IPARK3, OP_IPARK4, OP_IPARK5,
        OP_ICLK1, OP_ICLK2, OP_ICLK3,
        OP_DUTY
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       cos;    // sine pass works on angle plus a quarter turn
        logic [2:0] coef;   // horner coefficient select
    } t_cmd;

    localparam logic [5:0] LAST_STEP = 6'd57;

    function automatic logic [30:0] coef_of(input logic [2:0] idx);
        case (idx)
            3'd0:    return C11;
            3'd1:    return C9;
            3'd2:    return C7;
            3'd3:    return C5;
            3'd4:    return C3;
            3'd5:    return C1;
            default: return '0;
        endcase
    endfunction

    // microprogram: one command per step
    function automatic t_cmd prog(input logic [5:0] step);
        t_cmd       c;
        logic [5:0] rel;
        c.op   = OP_NOP;
        c.cos  = (step >= 6'd21);
        rel    = c.cos ? step - 6'd21 : step - 6'd4;
        c.coef = 3'(rel[5:1] - 5'd1);
        case (step) inside
            6'd0:  c.op = OP_TORQ_M1;
            6'd1:  c.op = OP_TORQ_M2;
            6'd2:  c.op = OP_TORQ_END;
            6'd3:  c.op = OP_BETA_END;
            [6'd4:6'd37]: begin
                case (rel) inside
                    6'd0:          c.op = OP_SIN_START;
                    6'd1:          c.op = OP_SIN_U2;
                    [6'd2:6'd13]:  c.op = rel[0] ? OP_SIN_HSUB : OP_SIN_HMUL;
                    6'd14:         c.op = OP_SIN_MUL_U;
                    6'd15:         c.op = OP_SIN_MUL_Y;
                    default:       c.op = OP_SIN_END;
                endcase
            end
            6'd38: c.op = OP_PARK1;
            6'd39: c.op = OP_PARK2;
            6'd40: c.op = OP_PARK3;
            6'd41: c.op = OP_PARK4;
            6'd42: c.op = OP_PARK5;
            6'd43: c.op = OP_INTEG;
            6'd44: c.op = OP_VOLT1;
            6'd45: c.op = OP_VOLT2;
            6'd46: c.op = OP_VOLT3;
            6'd47: c.op = OP_VOLT4;
            6'd48: c.op = OP_VOLT5;
            6'd49: c.op = OP_IPARK1;
            6'd50: c.op = OP_IPARK2;
            6'd51: c.op = OP_IPARK3;
            6'd52: c.op = OP_IPARK4;
            6'd53: c.op = OP_IPARK5;
            6'd54: c.op = OP_ICLK1;
            6'd55: c.op = OP_ICLK2;
            6'd56: c.op = OP_ICLK3;
            6'd57: c.op = OP_DUTY;
            default: c.op = OP_NOP;
        endcase
        return c;
    endfunction

    // round half up, then floor shift by 15
    function automatic logic signed [65:0] rnd15(input logic signed [65:0] x);
        return (x + 66'sd16384) >>> 15;
    endfunction

    // 2048 + floor((9v + 80) / 160), saturated to 0..4095
    function automatic logic [11:0] duty_of(input logic signed [17:0] v);
        logic signed [23:0] x;
        logic signed [18:0] y;
        logic [14:0]        t;
        logic [30:0]        q;
        x = (24'(v) <<< 3) + 24'(v) + 24'sd80;
        y = 19'(x >>> 5);
        t = 15'(y + 19'sd10240);
        q = 31'(t) * 31'd52429;
        if (y < -19'sd10240) begin
            return 12'd0;
        end else if (y >= 19'sd10240) begin
            return 12'd4095;
        end
        return q[29:18];
    endfunction

endpackage

FILE: design/focic_ctrl.sv
// ----------------------------------------------------------------------------
// focic_ctrl
// Sequencer: accepts a transaction, steps the microprogram, owns output valid.
// ----------------------------------------------------------------------------
module focic_ctrl
    import focic_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state     r_state;
    logic [5:0] r_step;
    logic       r_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd = prog(r_step);
        if (r_state == S_IDLE) begin
            o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
        end else if (r_step == LAST_STEP && !slot_free) begin
            o_cmd.op = OP_NOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step != LAST_STEP) begin
                        r_step <= r_step + 6'd1;
                    end else if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/focic_dp.sv
// ----------------------------------------------------------------------------
// focic_dp
// Datapath: configuration registers, loop state, one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
module focic_dp
    import focic_pkg::*;
#(
    parameter int POLE_PAIRS       = 7,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int TORQUE_LIMIT     = 50,
    parameter int ADC_BITS         = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    input  t_in                     i_in_data,
    input  t_cmd                    i_cmd,
    output t_out                    o_out_data
);

    localparam int SINE_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam logic [11:0] ADC_MASK =
        (ADC_BITS >= 12) ? 12'hFFF : 12'((1 << ADC_BITS) - 1);
    localparam logic signed [65:0] TQ_HI = 66'(TORQUE_LIMIT);
    localparam logic signed [65:0] TQ_LO = -TQ_HI;

    // configuration
    logic [31:0] r_kp, r_ki, r_spring, r_damper;
    logic [15:0] r_target, r_offset;
    logic [11:0] r_zero_a, r_zero_b;

    // loop state
    logic [15:0]        r_prev;
    logic signed [31:0] r_int_d, r_int_q;

    // per-transaction working registers
    logic [15:0]        r_el;
    logic signed [16:0] r_speed, r_perr, r_ed, r_eq;
    logic signed [12:0] r_ia;
    logic signed [14:0] r_sum;
    logic signed [11:0] r_iq_ref;
    logic signed [15:0] r_beta, r_sin, r_cos, r_id, r_iq, r_vd, r_vq;
    logic signed [17:0] r_val, r_vbe, r_vb, r_vc;
    logic signed [65:0] r_p, r_acc;
    logic [29:0]        r_u, r_u2;
    logic [30:0]        r_hs;
    logic [1:0]         r_quad;
    logic               r_full;
    t_out               r_out;

    // load-time combinational values
    logic [15:0]        el;
    logic [15:0]        d_speed, d_perr;
    logic [11:0]        sa, sb;
    logic signed [12:0] ia, ib;

    // sine index
    logic [15:0]          ang;
    logic [SINE_BITS-1:0] idx;
    logic [SINE_BITS:0]   k;
    logic [29:0]          u;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] sum_acc, dif_acc, torque, vsum, ivb, ivc;
    logic [16:0]        sin_mag;
    logic signed [15:0] sin_val;
    logic signed [32:0] int_d_next, int_q_next;

    function automatic logic signed [15:0] sat16(input logic signed [65:0] x);
        if (x > 66'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -66'sd32768) begin
            return 16'sh8000;
        end
        return 16'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
        if (x > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(x);
    endfunction

    always_comb begin
        el      = 16'(32'({i_in_data.encoder_angle, 4'b0000}) * 32'(POLE_PAIRS)) - r_offset;
        d_speed = el - r_prev;
        d_perr  = r_target - el;
        sa      = i_in_data.current_a_sample & ADC_MASK;
        sb      = i_in_data.current_b_sample & ADC_MASK;
        ia      = $signed({1'b0, sa}) - $signed({1'b0, r_zero_a});
        ib      = $signed({1'b0, sb}) - $signed({1'b0, r_zero_b});

        ang = r_el + (i_cmd.cos ? QUARTER_TURN : 16'd0);
        idx = ang[13 -: SINE_BITS];
        k   = ang[14] ? ((SINE_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
        u   = 30'(k[SINE_BITS-1:0]) << (30 - SINE_BITS);

        sum_acc = r_acc + r_p;
        dif_acc = r_acc - r_p;
        torque  = dif_acc >>> 16;
        vsum    = r_acc + (r_p >>> 16);
        ivb     = rnd15(sum_acc);
        ivc     = rnd15(dif_acc);

        sin_mag = 17'(((r_p + 66'sd536870912) >>> 30));
        if (r_full || sin_mag > 17'd32767) begin
            sin_val = 16'sd32767;
        end else begin
            sin_val = 16'(sin_mag);
        end
        if (r_quad[1]) begin
            sin_val = -sin_val;
        end

        // current errors formed here so the integrators see this transaction
        int_d_next = 33'(r_int_d) - 33'(r_id);
        int_q_next = 33'(r_int_q) + 33'(r_iq_ref) - 33'(r_iq);

        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_TORQ_M1:   begin mul_a = 33'(r_spring); mul_b = 33'(r_perr);  end
            OP_TORQ_M2:   begin mul_a = 33'(r_damper); mul_b = 33'(r_speed); end
            OP_TORQ_END:  begin mul_a = 33'(r_sum);    mul_b = INV_SQRT3_Q15; end
            OP_SIN_START: begin mul_a = 33'(u);        mul_b = 33'(u);       end
            OP_SIN_HMUL:  begin mul_a = 33'(r_hs);     mul_b = 33'(r_u2);    end
            OP_SIN_MUL_U: begin mul_a = 33'(r_hs);     mul_b = 33'(r_u);     end
            OP_SIN_MUL_Y: begin mul_a = 33'(r_p[60:30]); mul_b = SINE_SCALE; end
            OP_PARK1:     begin mul_a = 33'(r_ia);     mul_b = 33'(r_cos);   end
            OP_PARK2:     begin mul_a = 33'(r_beta);   mul_b = 33'(r_sin);   end
            OP_PARK3:     begin mul_a = 33'(r_beta);   mul_b = 33'(r_cos);   end
            OP_PARK4:     begin mul_a = 33'(r_ia);     mul_b = 33'(r_sin);   end
            OP_VOLT1:     begin mul_a = 33'(r_kp);     mul_b = 33'(r_ed);    end
            OP_VOLT2:     begin mul_a = 33'(r_ki);     mul_b = 33'(r_int_d); end
            OP_VOLT3:     begin mul_a = 33'(r_kp);     mul_b = 33'(r_eq);    end
            OP_VOLT4:     begin mul_a = 33'(r_ki);     mul_b = 33'(r_int_q); end
            OP_IPARK1:    begin mul_a = 33'(r_vd);     mul_b = 33'(r_cos);   end
            OP_IPARK2:    begin mul_a = 33'(r_vq);     mul_b = 33'(r_sin);   end
            OP_IPARK3:    begin mul_a = 33'(r_vd);     mul_b = 33'(r_sin);   end
            OP_IPARK4:    begin mul_a = 33'(r_vq);     mul_b = 33'(r_cos);   end
            OP_ICLK1:     begin mul_a = 33'(r_val);    mul_b = HALF_Q15;     end
            OP_ICLK2:     begin mul_a = 33'(r_vbe);    mul_b = HALF_SQRT3_Q15; end
            default:      begin mul_a = '0;            mul_b = '0;           end
        endcase
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= RST_CURRENT_KP;
            r_ki     <= RST_CURRENT_KI_TS;
            r_spring <= RST_SPRING_GAIN;
            r_damper <= RST_DAMPER_GAIN;
            r_target <= '0;
            r_offset <= '0;
            r_zero_a <= RST_ZERO_CURRENT;
            r_zero_b <= RST_ZERO_CURRENT;
            r_prev   <= '0;
            r_int_d  <= '0;
            r_int_q  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CURRENT_KP:        r_kp     <= i_cfg_data;
                    CFG_CURRENT_KI_TS:     r_ki     <= i_cfg_data;
                    CFG_SPRING_GAIN:       r_spring <= i_cfg_data;
                    CFG_DAMPER_GAIN:       r_damper <= i_cfg_data;
                    CFG_TARGET_ANGLE:      r_target <= i_cfg_data[15:0];
                    CFG_ELECTRICAL_OFFSET: r_offset <= i_cfg_data[15:0];
                    CFG_ZERO_CURRENT_A:    r_zero_a <= i_cfg_data[11:0];
                    CFG_ZERO_CURRENT_B:    r_zero_b <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                r_prev <= el;
            end
            if (i_cmd.op == OP_INTEG) begin
                r_int_d <= sat32(int_d_next);
                r_int_q <= sat32(int_q_next);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_p <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LOAD: begin
                r_el    <= el;
                // exactly half a turn counts as positive
                r_speed <= {(d_speed > 16'd32768), d_speed};
                r_perr  <= {(d_perr > 16'd32768), d_perr};
                r_ia    <= ia;
                r_sum   <= 15'(ia) + (15'(ib) <<< 1);
            end
            OP_TORQ_M2: r_acc <= r_p;
            OP_TORQ_END: begin
                if (torque > TQ_HI) begin
                    r_iq_ref <= 12'(TQ_HI);
                end else if (torque < TQ_LO) begin
                    r_iq_ref <= 12'(TQ_LO);
                end else begin
                    r_iq_ref <= 12'(torque);
                end
            end
            OP_BETA_END: r_beta <= 16'(rnd15(r_p));
            OP_SIN_START: begin
                r_u    <= u;
                r_quad <= ang[15:14];
                r_full <= k[SINE_BITS];
            end
            OP_SIN_U2: begin
                r_u2 <= r_p[59:30];
                r_hs <= C13;
            end
            OP_SIN_HSUB: r_hs <= coef_of(i_cmd.coef) - r_p[60:30];
            OP_SIN_END: begin
                if (i_cmd.cos) begin
                    r_cos <= sin_val;
                end else begin
                    r_sin <= sin_val;
                end
            end
            OP_PARK2:  r_acc <= r_p;
            OP_PARK3:  r_id  <= 16'(ivb);
            OP_PARK4:  r_acc <= r_p;
            OP_PARK5:  r_iq  <= 16'(ivc);
            OP_INTEG: begin
                r_ed <= -17'(r_id);
                r_eq <= 17'(r_iq_ref) - 17'(r_iq);
            end
            OP_VOLT2:  r_acc <= r_p >>> 16;
            OP_VOLT3:  r_vd  <= sat16(vsum);
            OP_VOLT4:  r_acc <= r_p >>> 16;
            OP_VOLT5:  r_vq  <= sat16(vsum);
            OP_IPARK2: r_acc <= r_p;
            OP_IPARK3: r_val <= 18'(ivc);
            OP_IPARK4: r_acc <= r_p;
            OP_IPARK5: r_vbe <= 18'(ivb);
            OP_ICLK2:  r_acc <= -r_p;
            OP_ICLK3: begin
                r_vb <= 18'(ivb);
                r_vc <= 18'(ivc);
            end
            OP_DUTY: begin
                r_out.duty_u <= duty_of(r_val);
                r_out.duty_v <= duty_of(r_vb);
                r_out.duty_w <= duty_of(r_vc);
            end
            default: ;
        endcase
    end

    assign o_out_data = r_out;

endmodule

FILE: design/foc_impedance_current_loop_unit.sv
// ----------------------------------------------------------------------------
// foc_impedance_current_loop_unit
// Field-oriented current loop with a virtual spring and damper: encoder angle
// and two phase currents in, three saturated centre-aligned duties out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_in_data  (t_in)
//  output   | out       | o_out_valid / i_out_stall  | o_out_data (t_out)
//  config   | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  one transaction is a load followed by a 58-step microprogram
//  that time-shares a single registered 33x33 multiplier (two sine evaluations
//  by polynomial account for 34 steps)
//  the next input is taken as soon as the sequencer is idle, even while the
//  last result still waits in the output register
//  a held output stalls only the final step, which writes the output register
//  synchronous active-low reset; no clearing pass, sines are computed on the fly
//  SINE_TABLE_DEPTH must be a power of two
// ----------------------------------------------------------------------------
module foc_impedance_current_loop_unit
    import focic_pkg::*;
#(
    parameter int POLE_PAIRS       = 7,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int TORQUE_LIMIT     = 50,
    parameter int ADC_BITS         = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    // sample transaction in
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in                     i_in_data,
    // duty transaction out
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out                    o_out_data
);

    // command from sequencer to datapath
    t_cmd cmd;

    focic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    focic_dp #(
        .POLE_PAIRS       (POLE_PAIRS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .TORQUE_LIMIT     (TORQUE_LIMIT),
        .ADC_BITS         (ADC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: tb/sv/foc_impedance_current_loop_unit_test.sv
// ----------------------------------------------------------------------------
// foc_impedance_current_loop_unit_test
// Self-checking bench for the impedance current loop: random and directed
// sample transactions against a bit-accurate predictor, with random idling on
// both channels, a long output hold-off and configuration phases.
// ----------------------------------------------------------------------------
module foc_impedance_current_loop_unit_test;
    import focic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POLES      = 7;
    localparam int TBL_DEPTH  = 1024;
    localparam int TRQ_LIMIT  = 50;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYC  = 80;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [31:0]             i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in                     i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out                    o_out_data;

    foc_impedance_current_loop_unit uut (.*);

    // predictor state and configuration copy
    logic [31:0] kp_q, ki_q, spring_q, damper_q;
    logic [15:0] target_q, offset_q, last_elec;
    logic [11:0] zero_a_q, zero_b_q;
    longint      integ_d, integ_q;
    logic [15:0] quarter_sine [TBL_DEPTH];

    t_in  sample_queue [$];
    t_out duty_queue [$];
    int   errors;
    int   accepted_in;
    int   accepted_out;
    int   idle_cycles;
    int   hold_off;
    bit   stim_done;
    bit   in_taken = 1'b0;

    // ------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // wrapped turn difference, half turn counts positive
    function automatic longint turn_delta(logic [15:0] a, logic [15:0] b);
        longint d;
        d = longint'(16'(a - b));
        if (d > 32768) d -= 65536;
        return d;
    endfunction

    function automatic longint sine_of(logic [15:0] a);
        longint unsigned idx, k;
        longint          v;
        idx = (longint'(a[13:0]) * TBL_DEPTH) >> 14;
        k   = a[14] ? TBL_DEPTH - idx : idx;
        v   = (k >= TBL_DEPTH) ? 32767 : longint'(quarter_sine[k]);
        return a[15] ? -v : v;
    endfunction

    function automatic logic [11:0] to_duty(longint v);
        longint n, q;
        n = 9 * v + 80;
        q = n / 160;
        if (n % 160 != 0 && n < 0) q -= 1;
        return 12'(clip(2048 + q, 0, 4095));
    endfunction

    task automatic build_sine_table();
        longint unsigned u, u2, s, y;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            u  = (longint'(i) << 30) / TBL_DEPTH;
            u2 = (u * u) >> 30;
            s  = 61;
            s  = 3864 - ((s * u2) >> 30);
            s  = 172272 - ((s * u2) >> 30);
            s  = 5026995 - ((s * u2) >> 30);
            s  = 85569306 - ((s * u2) >> 30);
            s  = 693598668 - ((s * u2) >> 30);
            s  = 1686629713 - ((s * u2) >> 30);
            y  = (s * u) >> 30;
            y  = (y * 32767 + (64'd1 << 29)) >> 30;
            quarter_sine[i] = 16'(y > 32767 ? 32767 : y);
        end
    endtask

    // one control tick of the loop: updates state, returns the duties
    function automatic t_out control_tick(t_in smp);
        logic [15:0] elec;
        longint speed, perr, torque, iq_ref, ia, ib, beta, sn, cs, id, iq;
        longint ed, eq, vd, vq, valpha, vbeta, vb, vc;
        t_out r;
        elec   = 16'(({4'd0, smp.encoder_angle} << 4) * POLES) - offset_q;
        speed  = turn_delta(elec, last_elec);
        perr   = turn_delta(target_q, elec);
        last_elec = elec;
        torque = longint'(spring_q) * perr - longint'(damper_q) * speed;
        iq_ref = clip(fshift(torque, 16), -TRQ_LIMIT, TRQ_LIMIT);
        ia     = longint'(smp.current_a_sample) - longint'(zero_a_q);
        ib     = longint'(smp.current_b_sample) - longint'(zero_b_q);
        beta   = rshift((ia + 2 * ib) * 18919, 15);
        sn     = sine_of(elec);
        cs     = sine_of(elec + QUARTER_TURN);
        id     = rshift(ia * cs + beta * sn, 15);
        iq     = rshift(beta * cs - ia * sn, 15);
        ed     = -id;
        eq     = iq_ref - iq;
        integ_d = clip(integ_d + ed, -64'sd2147483648, 64'sd2147483647);
        integ_q = clip(integ_q + eq, -64'sd2147483648, 64'sd2147483647);
        vd = clip(fshift(longint'(kp_q) * ed, 16) + fshift(longint'(ki_q) * integ_d, 16),
                  -32768, 32767);
        vq = clip(fshift(longint'(kp_q) * eq, 16) + fshift(longint'(ki_q) * integ_q, 16),
                  -32768, 32767);
        valpha = rshift(vd * cs - vq * sn, 15);
        vbeta  = rshift(vd * sn + vq * cs, 15);
        vb = rshift(-valpha * 16384 + vbeta * 28378, 15);
        vc = rshift(-valpha * 16384 - vbeta * 28378, 15);
        r.duty_u = to_duty(valpha);
        r.duty_v = to_duty(vb);
        r.duty_w = to_duty(vc);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // remembers whether the offered sample was taken at the last rising edge
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
    end

    // ------------------------------------------------------------------
    // driver: pops pending samples at the falling edge, random gaps
    // ------------------------------------------------------------------
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // stalled transaction holds its payload
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
            i_in_data  <= sample_queue.pop_front();
            i_in_valid <= 1'b1;
            // mostly back to back, some short gaps, rare long ones
            case ($urandom_range(0, 19))
                0:             gap_left = $urandom_range(40, 200);
                1, 2, 3, 4, 5: gap_left = $urandom_range(1, 6);
                default:       gap_left = 0;
            endcase
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver stall: random, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            i_out_stall <= 1'b1;
        end else begin
            case ($urandom_range(0, 29))
                0:          i_out_stall <= 1'b1;
                1, 2, 3, 4: i_out_stall <= ($urandom_range(0, 1) == 1);
                default:    i_out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on accepted inputs, checks accepted outputs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out exp_d;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                duty_queue.push_back(control_tick(i_in_data));
                accepted_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                accepted_out++;
                if (duty_queue.size() == 0) begin
                    $error("duty transaction with nothing expected: %h", o_out_data);
                    errors++;
                end else begin
                    exp_d = duty_queue.pop_front();
                    if (o_out_data.duty_u !== exp_d.duty_u) begin
                        $error("duty_u expected %0d actual %0d", exp_d.duty_u,
                               o_out_data.duty_u);
                        errors++;
                    end
                    if (o_out_data.duty_v !== exp_d.duty_v) begin
                        $error("duty_v expected %0d actual %0d", exp_d.duty_v,
                               o_out_data.duty_v);
                        errors++;
                    end
                    if (o_out_data.duty_w !== exp_d.duty_w) begin
                        $error("duty_w expected %0d actual %0d", exp_d.duty_w,
                               o_out_data.duty_w);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || stim_done
            || hold_off > 0) begin
            idle_cycles <= 0;
        end else if (i_rst_n && sample_queue.size() + duty_queue.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in rand_sample();
        t_in s;
        s.encoder_angle    = 12'($urandom);
        // currents mostly near the zero point, sometimes anywhere
        if ($urandom_range(0, 3) == 0) begin
            s.current_a_sample = 12'($urandom);
            s.current_b_sample = 12'($urandom);
        end else begin
            s.current_a_sample = 12'(int'(zero_a_q) + $urandom_range(0, 400) - 200);
            s.current_b_sample = 12'(int'(zero_b_q) + $urandom_range(0, 400) - 200);
        end
        return s;
    endfunction

    function automatic t_in mk(logic [11:0] enc, logic [11:0] a, logic [11:0] b);
        t_in s;
        s.encoder_angle    = enc;
        s.current_a_sample = a;
        s.current_b_sample = b;
        return s;
    endfunction

    // wait until all queued work has been accepted and answered
    task automatic drain();
        do begin
            @(posedge i_clk);
            #0.5;
        end while (sample_queue.size() != 0 || i_in_valid || duty_queue.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CURRENT_KP:        kp_q     = val;
            CFG_CURRENT_KI_TS:     ki_q     = val;
            CFG_SPRING_GAIN:       spring_q = val;
            CFG_DAMPER_GAIN:       damper_q = val;
            CFG_TARGET_ANGLE:      target_q = val[15:0];
            CFG_ELECTRICAL_OFFSET: offset_q = val[15:0];
            CFG_ZERO_CURRENT_A:    zero_a_q = val[11:0];
            CFG_ZERO_CURRENT_B:    zero_b_q = val[11:0];
            default: ;
        endcase
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) sample_queue.push_back(rand_sample());
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_in_data   = '0;
        errors      = 0;
        accepted_in = 0;
        accepted_out = 0;
        idle_cycles = 0;
        hold_off    = 0;
        stim_done   = 1'b0;
        build_sine_table();
        kp_q = RST_CURRENT_KP;  ki_q = RST_CURRENT_KI_TS;
        spring_q = RST_SPRING_GAIN;  damper_q = RST_DAMPER_GAIN;
        target_q = '0;  offset_q = '0;
        zero_a_q = RST_ZERO_CURRENT;  zero_b_q = RST_ZERO_CURRENT;
        last_elec = '0;  integ_d = 0;  integ_q = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: first tick measures speed from zero, field extremes,
        // quarter-turn lookups, half-turn differences
        sample_queue.push_back(mk(12'd0, 12'd1850, 12'd1850));
        sample_queue.push_back(mk(12'd4095, 12'd4095, 12'd4095));
        sample_queue.push_back(mk(12'd0, 12'd0, 12'd0));
        sample_queue.push_back(mk(12'd4095, 12'd0, 12'd4095));
        sample_queue.push_back(mk(12'd0, 12'd4095, 12'd0));
        sample_queue.push_back(mk(12'hAAA, 12'h555, 12'hAAA));
        sample_queue.push_back(mk(12'h555, 12'hAAA, 12'h555));
        // electrical quarter turns: encoder*112 = 16384*k hits the table end
        sample_queue.push_back(mk(12'd1024, 12'd2000, 12'd1700));
        sample_queue.push_back(mk(12'd2048, 12'd1700, 12'd2000));
        sample_queue.push_back(mk(12'd3072, 12'd1850, 12'd2100));
        sample_queue.push_back(mk(12'd0, 12'd1600, 12'd1850));
        drain();

        // half-turn error: target half a turn from the angle
        write_reg(CFG_TARGET_ANGLE, 32'h8000);
        sample_queue.push_back(mk(12'd0, 12'd1850, 12'd1850));
        sample_queue.push_back(mk(12'd0, 12'd1900, 12'd1800));
        drain();

        random_phase(300);

        // saturating gains: drive integrators and voltages to their limits
        write_reg(CFG_CURRENT_KP, 32'hFFFF_FFFF);
        write_reg(CFG_CURRENT_KI_TS, 32'hFFFF_FFFF);
        write_reg(CFG_SPRING_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_DAMPER_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_TARGET_ANGLE, 32'hFFFF);
        write_reg(CFG_ELECTRICAL_OFFSET, 32'hFFFF);
        write_reg(CFG_ZERO_CURRENT_A, 32'hFFF);
        write_reg(CFG_ZERO_CURRENT_B, 32'h000);
        random_phase(250);

        // zero gains
        write_reg(CFG_CURRENT_KP, 32'd0);
        write_reg(CFG_CURRENT_KI_TS, 32'd0);
        write_reg(CFG_SPRING_GAIN, 32'd0);
        write_reg(CFG_DAMPER_GAIN, 32'd0);
        write_reg(CFG_TARGET_ANGLE, 32'd0);
        write_reg(CFG_ELECTRICAL_OFFSET, 32'd0);
        write_reg(CFG_ZERO_CURRENT_A, 32'd0);
        write_reg(CFG_ZERO_CURRENT_B, 32'hFFF);
        random_phase(200);

        // out-of-range index is ignored, then random moderate settings
        write_reg(4'd8 + 4'($urandom_range(0, 7)), $urandom);
        write_reg(CFG_CURRENT_KP, $urandom_range(0, 32'h0100_0000));
        write_reg(CFG_CURRENT_KI_TS, $urandom_range(0, 32'h0010_0000));
        write_reg(CFG_SPRING_GAIN, $urandom_range(0, 100000));
        write_reg(CFG_DAMPER_GAIN, $urandom_range(0, 2000000));
        write_reg(CFG_TARGET_ANGLE, $urandom);
        write_reg(CFG_ELECTRICAL_OFFSET, $urandom);
        write_reg(CFG_ZERO_CURRENT_A, $urandom_range(1700, 2300));
        write_reg(CFG_ZERO_CURRENT_B, $urandom_range(1700, 2300));

        // long receiver hold-off while the sender keeps offering
        hold_off = 600;
        random_phase(300);

        // gains and current zero points back to reset values, random angles
        write_reg(CFG_CURRENT_KP, RST_CURRENT_KP);
        write_reg(CFG_CURRENT_KI_TS, RST_CURRENT_KI_TS);
        write_reg(CFG_SPRING_GAIN, RST_SPRING_GAIN);
        write_reg(CFG_DAMPER_GAIN, RST_DAMPER_GAIN);
        write_reg(CFG_TARGET_ANGLE, $urandom);
        write_reg(CFG_ELECTRICAL_OFFSET, $urandom);
        write_reg(CFG_ZERO_CURRENT_A, RST_ZERO_CURRENT);
        write_reg(CFG_ZERO_CURRENT_B, RST_ZERO_CURRENT);
        random_phase(490);

        stim_done = 1'b1;
        $display("covered %0d sample transactions and %0d duty transactions", accepted_in,
                 accepted_out);
        $display("over five register settings including zero and full-scale gains");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
